/* design/csv_record_splitter_top_assert.svh */
// assertion macros for the csv record splitter checker
`ifndef CSV_RECORD_SPLITTER_TOP_ASSERT_SVH
`define CSV_RECORD_SPLITTER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CSVRS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csvrs check failed");

// next-cycle implication, sampled on clk, off during reset
`define CSVRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csvrs check failed");

`endif

/* design/csvrs_pkg.sv */
package csvrs_pkg;

    localparam int LENGTH_BITS_DEF = 24;
    localparam int RECORD_LENGTH_W = 24;
    localparam int MAX_BYTES_W     = 25;

    localparam logic [MAX_BYTES_W-1:0] MAX_BYTES_RESET = 25'd65536;

    // result kinds
    localparam logic [2:0] KIND_DATA       = 3'd0;
    localparam logic [2:0] KIND_END        = 3'd1;
    localparam logic [2:0] KIND_OVERFLOW   = 3'd2;
    localparam logic [2:0] KIND_UNCLOSED   = 3'd3;
    localparam logic [2:0] KIND_STREAM_END = 3'd4;

    // special characters
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } src_item_t;

    typedef struct packed {
        logic [2:0]                 kind;
        logic [7:0]                 out_byte;
        logic [RECORD_LENGTH_W-1:0] rec_len;
    } rec_item_t;

    typedef struct packed {
        logic      emit;
        rec_item_t item;
    } step_res_t;

endpackage

/* design/csv_record_splitter_top.sv */
// csv record splitter: one stream word in, zero or one record word out
// path: input word register, then result word register, then out on rec
// throughput: one word per cycle, limited only by rec_stall back pressure
// reset: rst_n async active low clears quoting state, length and both word valid flags
// reset: the size limit returns to 65536
module csv_record_splitter_top
    import csvrs_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // incoming stream words
    input  logic                   src_valid,
    output logic                   src_stall,
    input  src_item_t              src_data,
    // outgoing record words
    output logic                   rec_valid,
    input  logic                   rec_stall,
    output rec_item_t              rec_data,
    // size limit register
    input  logic                   cfg_we,
    input  logic [MAX_BYTES_W-1:0] cfg_wdata
);

    // input word register
    logic      in_valid_reg;
    src_item_t in_data_reg;

    // result word register
    logic      out_valid_reg;
    rec_item_t out_data_reg;

    step_res_t res;
    logic      advance;

    // the input word moves on whenever the result slot is free or being drained
    assign advance   = !out_valid_reg || !rec_stall;
    // only hold off the source when a word is parked and cannot move
    assign src_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!src_stall)
        begin
            in_valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && !src_stall)
        begin
            in_data_reg <= src_data;
        end
    end

    // parser state update and result decode for the parked word
    csvrs_step #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .take      (in_valid_reg && advance),
        .item      (in_data_reg),
        .res       (res)
    );

    // words that give no result (swallowed lf) simply leave the slot empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg && res.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg && res.emit)
        begin
            out_data_reg <= res.item;
        end
    end

    assign rec_valid = out_valid_reg;
    assign rec_data  = out_data_reg;

endmodule

/* design/csvrs_step.sv */
module csvrs_step
    import csvrs_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [MAX_BYTES_W-1:0] cfg_wdata,
    input  logic                   take,
    input  src_item_t              item,
    output step_res_t              res
);

    // compare width covers length+2 and the limit register
    localparam int CW = (LENGTH_BITS + 2 > MAX_BYTES_W + 1) ? LENGTH_BITS + 2 : MAX_BYTES_W + 1;

    logic [MAX_BYTES_W-1:0] max_bytes_reg;
    logic                   inside_quotes_reg, inside_quotes_next;
    logic                   closing_quote_reg, closing_quote_next;
    logic                   skip_lf_reg, skip_lf_next;
    logic [LENGTH_BITS-1:0] bytes_reg, bytes_next;

    logic [CW-1:0] len_ext;
    logic [CW-1:0] len_plus2;
    logic [CW-1:0] max_ext;
    logic          fits;

    assign len_ext   = CW'(bytes_reg);
    assign len_plus2 = len_ext + CW'(2);
    assign max_ext   = CW'(max_bytes_reg);
    assign fits      = (len_plus2 <= max_ext) && (bytes_reg != {LENGTH_BITS{1'b1}});

    always_comb
    begin
        logic       do_app;
        logic       quote_set;
        logic [7:0] app_byte;
        logic [7:0] b;

        b        = item.in_byte;
        do_app   = 1'b0;
        quote_set = 1'b0;
        app_byte = b;

        inside_quotes_next = inside_quotes_reg;
        closing_quote_next = closing_quote_reg;
        skip_lf_next       = skip_lf_reg;
        bytes_next         = bytes_reg;

        res.emit          = 1'b0;
        res.item.kind     = KIND_DATA;
        res.item.out_byte = 8'd0;
        res.item.rec_len  = '0;

        if (item.end_of_input)
        begin
            res.emit           = 1'b1;
            inside_quotes_next = 1'b0;
            closing_quote_next = 1'b0;
            skip_lf_next       = 1'b0;
            bytes_next         = '0;
            if (bytes_reg == '0)
            begin
                res.item.kind = KIND_STREAM_END;
            end
            else if (inside_quotes_reg && !closing_quote_reg)
            begin
                res.item.kind = KIND_UNCLOSED;
            end
            else
            begin
                res.item.kind    = KIND_END;
                res.item.rec_len = len_ext[RECORD_LENGTH_W-1:0];
            end
        end
        else if (!(skip_lf_reg && b == CH_LF))
        begin
            skip_lf_next       = 1'b0;
            closing_quote_next = 1'b0;
            if (closing_quote_reg && b == CH_QUOTE)
            begin
                // doubled quote, second byte
                do_app = 1'b1;
            end
            else
            begin
                if (closing_quote_reg)
                begin
                    inside_quotes_next = 1'b0;
                end
                if (b == CH_QUOTE)
                begin
                    do_app    = 1'b1;
                    quote_set = 1'b1;
                end
                else if (b == CH_LF || b == CH_CR)
                begin
                    skip_lf_next = (b == CH_CR);
                    if (!inside_quotes_next)
                    begin
                        res.emit         = 1'b1;
                        res.item.kind    = KIND_END;
                        res.item.rec_len = len_ext[RECORD_LENGTH_W-1:0];
                        bytes_next       = '0;
                    end
                    else
                    begin
                        do_app   = 1'b1;
                        app_byte = CH_LF;
                    end
                end
                else
                begin
                    do_app = 1'b1;
                end
            end

            if (do_app)
            begin
                res.emit = 1'b1;
                if (fits)
                begin
                    bytes_next        = bytes_reg + LENGTH_BITS'(1);
                    res.item.out_byte = app_byte;
                    if (quote_set)
                    begin
                        if (inside_quotes_next)
                        begin
                            closing_quote_next = 1'b1;
                        end
                        else
                        begin
                            inside_quotes_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    // record state dropped, pending lf skip after cr kept
                    res.item.kind      = KIND_OVERFLOW;
                    inside_quotes_next = 1'b0;
                    closing_quote_next = 1'b0;
                    bytes_next         = '0;
                end
            end
        end
        else
        begin
            // lf right after cr is swallowed
            skip_lf_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg     <= MAX_BYTES_RESET;
            inside_quotes_reg <= 1'b0;
            closing_quote_reg <= 1'b0;
            skip_lf_reg       <= 1'b0;
            bytes_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_bytes_reg <= cfg_wdata;
            end
            if (take)
            begin
                inside_quotes_reg <= inside_quotes_next;
                closing_quote_reg <= closing_quote_next;
                skip_lf_reg       <= skip_lf_next;
                bytes_reg         <= bytes_next;
            end
        end
    end

endmodule

/* design/csvrs_checker.sv */
`include "csv_record_splitter_top_assert.svh"

module csvrs_checker
    import csvrs_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      src_stall,
    input logic      rec_valid,
    input logic      rec_stall,
    input rec_item_t rec_data
);

    // a stalled result word holds
    `CSVRS_ASSERT_NEXT(a_rec_hold, rec_valid && rec_stall, rec_valid && $stable(rec_data))

    // only known kinds come out
    `CSVRS_ASSERT_NOW(a_kind_range, rec_valid, rec_data.kind <= KIND_STREAM_END)

    // length only on record end
    `CSVRS_ASSERT_NOW(a_len_only_end, rec_valid && rec_data.kind != KIND_END, rec_data.rec_len == '0)

    // byte only on data words
    `CSVRS_ASSERT_NOW(a_byte_only_data, rec_valid && rec_data.kind != KIND_DATA, rec_data.out_byte == 8'd0)

    // the source is held off only while a result word waits
    `CSVRS_ASSERT_NOW(a_stall_cause, src_stall, rec_valid && rec_stall)

endmodule

bind csv_record_splitter_top csvrs_checker u_csvrs_checker (.*);
